@@ hw/rtl/lspi_pkg.sv @@
`default_nettype none

package lspi_pkg;

    localparam int OFFSET_W         = 16;
    localparam int GAIN_W           = 16;
    localparam int LIMIT_W          = 16;
    localparam int DECEL_W          = 10;
    localparam int SPEED_W          = 10;
    localparam int STEER_W          = 12;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    localparam int OFFSET_FRAC_BITS = 4;
    localparam int GAIN_FRAC_BITS   = 8;
    localparam int PROD_FRAC_BITS   = OFFSET_FRAC_BITS + GAIN_FRAC_BITS;

    localparam int PROD_W           = 32;
    localparam int INTEG_W          = 29;
    localparam int ACC_W            = 33;
    localparam int PI_W             = 16;
    localparam int STEER_EXT_W      = 18;
    localparam int MAG_W            = 12;
    localparam int DEN_W            = 12;
    localparam int NUM_W            = 2 * DECEL_W;
    localparam int DIV_STEPS        = NUM_W;
    localparam int CNT_W            = 5;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_WINDUP_LIMIT = 3'd2,
        REG_DECEL_CONST  = 3'd3,
        REG_TARGET_SPEED = 3'd4,
        REG_STEER_CENTER = 3'd5,
        REG_STEER_MIN    = 3'd6,
        REG_STEER_MAX    = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  gain_p;
        logic [GAIN_W-1:0]  gain_i;
        logic [LIMIT_W-1:0] windup_limit;
        logic [DECEL_W-1:0] decel_const;
        logic [SPEED_W-1:0] target_speed;
        logic [STEER_W-1:0] steer_center;
        logic [STEER_W-1:0] steer_min;
        logic [STEER_W-1:0] steer_max;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        gain_p:       16'd3840,
        gain_i:       16'd0,
        windup_limit: 16'd500,
        decel_const:  10'd150,
        target_speed: 10'd200,
        steer_center: 12'd1500,
        steer_min:    12'd1000,
        steer_max:    12'd2000
    };

    typedef struct packed {
        logic load;
        logic mul_i;
        logic integ;
        logic mul_p;
        logic pi_sum;
        logic pi_sat;
        logic steer;
        logic div_init;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

endpackage

`default_nettype wire

@@ hw/rtl/lspi_regs.sv @@
`default_nettype none

module lspi_regs
    import lspi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_GAIN_P:       cfg_next.gain_p       = cfg_data;
                REG_GAIN_I:       cfg_next.gain_i       = cfg_data;
                REG_WINDUP_LIMIT: cfg_next.windup_limit = cfg_data;
                REG_DECEL_CONST:  cfg_next.decel_const  = cfg_data[DECEL_W-1:0];
                REG_TARGET_SPEED: cfg_next.target_speed = cfg_data[SPEED_W-1:0];
                REG_STEER_CENTER: cfg_next.steer_center = cfg_data[STEER_W-1:0];
                REG_STEER_MIN:    cfg_next.steer_min    = cfg_data[STEER_W-1:0];
                REG_STEER_MAX:    cfg_next.steer_max    = cfg_data[STEER_W-1:0];
                default:          cfg_next              = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/lspi_dp.sv @@
`default_nettype none

module lspi_dp
    import lspi_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire dp_cmd_t                    cmd,
    input  wire cfg_t                       cfg,
    input  wire logic signed [OFFSET_W-1:0] lane_offset,
    output logic [STEER_W-1:0]              steering_cmd,
    output logic [SPEED_W-1:0]              speed_cmd
);

    logic signed [OFFSET_W-1:0] offset_reg;
    logic [MAG_W-1:0]           mag_reg;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [INTEG_W-1:0]  integ_reg;
    logic signed [INTEG_W-1:0]  integ_next;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [PI_W-1:0]     pi_reg;
    logic [STEER_W-1:0]         steer_reg;
    logic [NUM_W-1:0]           num_reg;
    logic [DEN_W-1:0]           den_reg;
    logic [DEN_W-1:0]           rem_reg;
    logic [STEER_W-1:0]         steering_reg;
    logic [SPEED_W-1:0]         speed_reg;

    logic [OFFSET_W:0]          off_ext;
    logic [OFFSET_W:0]          off_abs;
    logic [GAIN_W-1:0]          mul_gain;
    logic signed [GAIN_W:0]     gain_s;
    logic signed [ACC_W-1:0]    prod_full;
    logic signed [ACC_W-1:0]    sum_all;
    logic signed [ACC_W-1:0]    limit_s;
    logic signed [ACC_W-1:0]    integ_clamp;
    logic signed [ACC_W-1:0]    bias;
    logic signed [ACC_W-1:0]    acc_biased;
    logic signed [ACC_W-1:0]    pi_full;
    logic signed [PI_W-1:0]     pi_sat;
    logic signed [STEER_EXT_W-1:0] steer_raw;
    logic signed [STEER_EXT_W-1:0] steer_hi;
    logic signed [STEER_EXT_W-1:0] steer_lo;
    logic signed [STEER_EXT_W-1:0] max_s;
    logic signed [STEER_EXT_W-1:0] min_s;
    logic [DEN_W:0]             trial;
    logic                       q_bit;
    logic [DEN_W-1:0]           rem_step;

    assign off_ext = {lane_offset[OFFSET_W-1], lane_offset};
    assign off_abs = lane_offset[OFFSET_W-1] ? (~off_ext + 1'b1) : off_ext;

    assign mul_gain  = cmd.mul_i ? cfg.gain_i : cfg.gain_p;
    assign gain_s    = {1'b0, mul_gain};
    assign prod_full = ACC_W'(offset_reg) * ACC_W'(gain_s);

    assign sum_all = ACC_W'(prod_reg) + ACC_W'(integ_reg);
    assign limit_s = {{(ACC_W - LIMIT_W - PROD_FRAC_BITS){1'b0}}, cfg.windup_limit,
                      {PROD_FRAC_BITS{1'b0}}};

    always_comb
    begin
        priority if (sum_all > limit_s)
        begin
            integ_clamp = limit_s;
        end
        else if (sum_all < -limit_s)
        begin
            integ_clamp = -limit_s;
        end
        else
        begin
            integ_clamp = sum_all;
        end
    end

    assign integ_next = integ_clamp[INTEG_W-1:0];

    // Adding 2^F - 1 before the arithmetic shift makes negative values round toward zero.
    assign bias       = {{(ACC_W - PROD_FRAC_BITS){1'b0}}, {PROD_FRAC_BITS{acc_reg[ACC_W-1]}}};
    assign acc_biased = acc_reg + bias;
    assign pi_full    = acc_biased >>> PROD_FRAC_BITS;

    always_comb
    begin
        priority if (pi_full > ACC_W'(signed'(17'sd32767)))
        begin
            pi_sat = 16'sh7FFF;
        end
        else if (pi_full < -(ACC_W'(signed'(17'sd32768))))
        begin
            pi_sat = 16'sh8000;
        end
        else
        begin
            pi_sat = pi_full[PI_W-1:0];
        end
    end

    assign max_s     = {{(STEER_EXT_W - STEER_W){1'b0}}, cfg.steer_max};
    assign min_s     = {{(STEER_EXT_W - STEER_W){1'b0}}, cfg.steer_min};
    assign steer_raw = signed'({{(STEER_EXT_W - STEER_W){1'b0}}, cfg.steer_center})
                       + STEER_EXT_W'(pi_reg);
    assign steer_hi  = (steer_raw > max_s) ? max_s : steer_raw;
    assign steer_lo  = (steer_hi < min_s) ? min_s : steer_hi;

    assign trial    = {rem_reg, num_reg[NUM_W-1]};
    assign q_bit    = (trial >= {1'b0, den_reg});
    assign rem_step = q_bit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integ_reg <= '0;
        end
        else if (cmd.integ)
        begin
            integ_reg <= integ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            offset_reg <= lane_offset;
            mag_reg    <= off_abs[OFFSET_FRAC_BITS+MAG_W-1:OFFSET_FRAC_BITS];
        end
        if (cmd.mul_i || cmd.mul_p)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
        if (cmd.pi_sum)
        begin
            acc_reg <= sum_all;
        end
        if (cmd.pi_sat)
        begin
            pi_reg <= pi_sat;
        end
        if (cmd.steer)
        begin
            steer_reg <= steer_lo[STEER_W-1:0];
        end
        if (cmd.div_init)
        begin
            num_reg <= NUM_W'(cfg.target_speed) * NUM_W'(cfg.decel_const);
            den_reg <= DEN_W'(cfg.decel_const) + mag_reg;
            rem_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            num_reg <= {num_reg[NUM_W-2:0], q_bit};
            rem_reg <= rem_step;
        end
        if (cmd.out_load)
        begin
            steering_reg <= steer_reg;
            speed_reg    <= (den_reg == '0) ? '0 : num_reg[SPEED_W-1:0];
        end
    end

    assign steering_cmd = steering_reg;
    assign speed_cmd    = speed_reg;

endmodule

`default_nettype wire

@@ hw/rtl/lspi_ctrl.sv @@
`default_nettype none

module lspi_ctrl
    import lspi_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    output dp_cmd_t   cmd
);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_MULI   = 10'b0000000010,
        S_INTEG  = 10'b0000000100,
        S_MULP   = 10'b0000001000,
        S_PISUM  = 10'b0000010000,
        S_PISAT  = 10'b0000100000,
        S_STEER  = 10'b0001000000,
        S_DIVI   = 10'b0010000000,
        S_DIV    = 10'b0100000000,
        S_FINISH = 10'b1000000000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_MULI;
                end
            end
            S_MULI:
            begin
                cmd.mul_i  = 1'b1;
                state_next = S_INTEG;
            end
            S_INTEG:
            begin
                cmd.integ  = 1'b1;
                state_next = S_MULP;
            end
            S_MULP:
            begin
                cmd.mul_p  = 1'b1;
                state_next = S_PISUM;
            end
            S_PISUM:
            begin
                cmd.pi_sum = 1'b1;
                state_next = S_PISAT;
            end
            S_PISAT:
            begin
                cmd.pi_sat = 1'b1;
                state_next = S_STEER;
            end
            S_STEER:
            begin
                cmd.steer  = 1'b1;
                state_next = S_DIVI;
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.out_load | (out_valid_reg & ~out_ready);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_out_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("result load did not raise out_valid");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg < CNT_W'(DIV_STEPS)))
        else $error("divider step count out of range");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_MULI))
        else $error("accepted word did not start processing");

endmodule

`default_nettype wire

@@ hw/rtl/lane_steering_pi_controller.sv @@
`default_nettype none

// Channel  Handshake              Payload
// cfg      cfg_valid/cfg_ready    cfg_index[2:0], cfg_data[15:0]
// in       in_valid/in_ready      lane_offset[15:0] (signed Q11.4)
// out      out_valid/out_ready    steering_cmd[11:0], speed_cmd[9:0]
//
// A word is accepted in idle; the controller then runs the multiplies, integral clamp and steering
// clamp, starts and steps the restoring divider that forms the speed quotient and loads the output
// register, and only then returns to idle to take the next word.
// A result not yet taken holds the controller in its last cycle, which stalls the input.
// Reset clears the controller and the integral accumulator and restores register defaults.
// Configuration writes are taken every cycle.

module lane_steering_pi_controller
    import lspi_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [OFFSET_W-1:0] lane_offset,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [STEER_W-1:0]              steering_cmd,
    output logic [SPEED_W-1:0]              speed_cmd
);

    cfg_t    cfg;
    dp_cmd_t cmd;

    lspi_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lspi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    lspi_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg          (cfg),
        .lane_offset  (lane_offset),
        .steering_cmd (steering_cmd),
        .speed_cmd    (speed_cmd)
    );

endmodule

`default_nettype wire

@@ verif/lane_steering_pi_controller_tb.sv @@
`default_nettype none

module lane_steering_pi_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lspi_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_STALL    = 400;
    localparam int PHASES        = 12;
    localparam int PHASE_WORDS   = 140;
    localparam int PLAN_LEN      = 36;

    typedef struct packed {
        logic [STEER_W-1:0] steering;
        logic [SPEED_W-1:0] speed;
    } cmd_pair_t;

    typedef enum logic {
        ROW_CFG,
        ROW_WORD
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        reg_index_t            idx;
        logic [CFG_DATA_W-1:0] value;
        logic                  typed_ok;
        cmd_pair_t             typed;
    } plan_row_t;

    localparam cmd_pair_t NO_CMD = '0;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index;
    logic [CFG_DATA_W-1:0]      cfg_data;
    logic                       in_valid;
    logic                       in_ready;
    logic signed [OFFSET_W-1:0] lane_offset;
    logic                       out_valid;
    logic                       out_ready;
    logic [STEER_W-1:0]         steering_cmd;
    logic [SPEED_W-1:0]         speed_cmd;

    cmd_pair_t expected_cmds [$];
    cfg_t      cfg;
    longint    integral_acc;
    int        mismatches;
    int        results_seen;
    int        stall_left;
    bit        idle_on;
    bit        long_stall_req;

    // Directed words: reset settings first, then saturation, integral clamping,
    // inverted steering limits and a zero speed divisor.
    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_WORD, REG_GAIN_P,       16'h0000, 1'b1, '{12'd1500, 10'd200}},
        '{ROW_WORD, REG_GAIN_P,       16'h0010, 1'b1, '{12'd1515, 10'd198}},
        '{ROW_WORD, REG_GAIN_P,       16'hFFF0, 1'b1, '{12'd1485, 10'd198}},
        '{ROW_WORD, REG_GAIN_P,       16'hFFFF, 1'b1, '{12'd1500, 10'd200}},
        '{ROW_WORD, REG_GAIN_P,       16'h000F, 1'b1, '{12'd1514, 10'd200}},
        '{ROW_WORD, REG_GAIN_P,       16'h7FFF, 1'b1, '{12'd2000, 10'd13}},
        '{ROW_WORD, REG_GAIN_P,       16'h8000, 1'b1, '{12'd1000, 10'd13}},
        '{ROW_CFG,  REG_GAIN_P,       16'hFFFF, 1'b0, NO_CMD},
        '{ROW_CFG,  REG_STEER_CENTER, 16'h0000, 1'b0, NO_CMD},
        '{ROW_CFG,  REG_STEER_MIN,    16'h0000, 1'b0, NO_CMD},
        '{ROW_CFG,  REG_STEER_MAX,    16'h0FFF, 1'b0, NO_CMD},
        '{ROW_WORD, REG_GAIN_P,       16'h7FFF, 1'b1, '{12'd4095, 10'd13}},
        '{ROW_WORD, REG_GAIN_P,       16'h8000, 1'b1, '{12'd0,    10'd13}},
        '{ROW_CFG,  REG_GAIN_P,       16'h0000, 1'b0, NO_CMD},
        '{ROW_CFG,  REG_GAIN_I,       16'hFFFF, 1'b0, NO_CMD},
        '{ROW_CFG,  REG_WINDUP_LIMIT, 16'h0001, 1'b0, NO_CMD},
        '{ROW_CFG,  REG_STEER_CENTER, 16'h0800, 1'b0, NO_CMD},
        '{ROW_WORD, REG_GAIN_P,       16'h7FFF, 1'b0, NO_CMD},
        '{ROW_WORD, REG_GAIN_P,       16'h8000, 1'b0, NO_CMD},
        '{ROW_WORD, REG_GAIN_P,       16'h0100, 1'b0, NO_CMD},
        '{ROW_CFG,  REG_WINDUP_LIMIT, 16'hFFFF, 1'b0, NO_CMD},
        '{ROW_WORD, REG_GAIN_P,       16'h7FFF, 1'b0, NO_CMD},
        '{ROW_WORD, REG_GAIN_P,       16'h7FFF, 1'b0, NO_CMD},
        '{ROW_CFG,  REG_STEER_MIN,    16'h0BB8, 1'b0, NO_CMD},
        '{ROW_CFG,  REG_STEER_MAX,    16'h03E8, 1'b0, NO_CMD},
        '{ROW_WORD, REG_GAIN_P,       16'h0000, 1'b1, '{12'd3000, 10'd200}},
        '{ROW_WORD, REG_GAIN_P,       16'h8000, 1'b1, '{12'd3000, 10'd13}},
        '{ROW_CFG,  REG_GAIN_I,       16'h0000, 1'b0, NO_CMD},
        '{ROW_CFG,  REG_DECEL_CONST,  16'h0000, 1'b0, NO_CMD},
        '{ROW_CFG,  REG_TARGET_SPEED, 16'h03FF, 1'b0, NO_CMD},
        '{ROW_WORD, REG_GAIN_P,       16'h0000, 1'b1, '{12'd3000, 10'd0}},
        '{ROW_WORD, REG_GAIN_P,       16'h000F, 1'b1, '{12'd3000, 10'd0}},
        '{ROW_WORD, REG_GAIN_P,       16'h00A0, 1'b1, '{12'd3000, 10'd0}},
        '{ROW_CFG,  REG_DECEL_CONST,  16'h03FF, 1'b0, NO_CMD},
        '{ROW_WORD, REG_GAIN_P,       16'h8000, 1'b1, '{12'd3000, 10'd340}},
        '{ROW_WORD, REG_GAIN_P,       16'h7FFF, 1'b1, '{12'd3000, 10'd340}}
    };

    lane_steering_pi_controller u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .lane_offset  (lane_offset),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .steering_cmd (steering_cmd),
        .speed_cmd    (speed_cmd)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic cmd_pair_t next_commands(input logic signed [OFFSET_W-1:0] off);
        longint    o;
        longint    bound;
        longint    pi;
        longint    st;
        longint    mag;
        longint    den;
        longint    sp;
        cmd_pair_t r;
        o = off;
        bound = longint'(cfg.windup_limit) << PROD_FRAC_BITS;
        integral_acc += o * longint'(cfg.gain_i);
        if (integral_acc > bound)
            integral_acc = bound;
        if (integral_acc < -bound)
            integral_acc = -bound;
        pi = o * longint'(cfg.gain_p) + integral_acc;
        pi = (pi < 0) ? -((-pi) >> PROD_FRAC_BITS) : (pi >> PROD_FRAC_BITS);
        if (pi > 32767)
            pi = 32767;
        if (pi < -32768)
            pi = -32768;
        st = longint'(cfg.steer_center) + pi;
        if (st > longint'(cfg.steer_max))
            st = longint'(cfg.steer_max);
        if (st < longint'(cfg.steer_min))
            st = longint'(cfg.steer_min);
        mag = ((o < 0) ? -o : o) >> OFFSET_FRAC_BITS;
        den = longint'(cfg.decel_const) + mag;
        sp = (den == 0) ? 0 : longint'(cfg.target_speed) * longint'(cfg.decel_const) / den;
        r.steering = st[STEER_W-1:0];
        r.speed = sp[SPEED_W-1:0];
        return r;
    endfunction

    function automatic logic signed [OFFSET_W-1:0] rand_offset();
        logic signed [OFFSET_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = 16'($urandom);
            1: v = ($urandom_range(0, 1) == 1) ? 16'h7FFF : 16'h8000;
            2: v = ($urandom_range(0, 1) == 1) ? 16'h0000 : 16'hFFFF;
            default: v = 16'($urandom_range(0, 2047)) - 16'd1024;
        endcase
        return v;
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GAIN_P:       cfg.gain_p = data;
            REG_GAIN_I:       cfg.gain_i = data;
            REG_WINDUP_LIMIT: cfg.windup_limit = data;
            REG_DECEL_CONST:  cfg.decel_const = data[DECEL_W-1:0];
            REG_TARGET_SPEED: cfg.target_speed = data[SPEED_W-1:0];
            REG_STEER_CENTER: cfg.steer_center = data[STEER_W-1:0];
            REG_STEER_MIN:    cfg.steer_min = data[STEER_W-1:0];
            REG_STEER_MAX:    cfg.steer_max = data[STEER_W-1:0];
        endcase
        @(posedge clk);
    endtask

    task automatic push_offset(input logic signed [OFFSET_W-1:0] v, input logic typed_ok,
                               input cmd_pair_t typed);
        cmd_pair_t got;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        lane_offset <= v;
        do
            @(posedge clk);
        while (!in_ready);
        got = next_commands(v);
        expected_cmds.push_back(typed_ok ? typed : got);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_cmds.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_phase_config(input bit wild);
        logic [CFG_DATA_W-1:0] vals [8];
        logic [CFG_DATA_W-1:0] mask;
        logic [CFG_DATA_W-1:0] raw;
        int                    center;
        center = $urandom_range(1000, 3000);
        vals[REG_GAIN_P]       = 16'($urandom_range(0, 8191));
        vals[REG_GAIN_I]       = 16'($urandom_range(0, 511));
        vals[REG_WINDUP_LIMIT] = 16'($urandom_range(0, 4095));
        vals[REG_DECEL_CONST]  = 16'($urandom_range(1, 1023));
        vals[REG_TARGET_SPEED] = 16'($urandom_range(0, 1023));
        vals[REG_STEER_CENTER] = 16'(center);
        vals[REG_STEER_MIN]    = 16'($urandom_range(0, center));
        vals[REG_STEER_MAX]    = 16'($urandom_range(center, 4095));
        if (wild)
        begin
            for (int i = 0; i < 8; i++)
            begin
                case (reg_index_t'(i))
                    REG_DECEL_CONST:  mask = 16'((1 << DECEL_W) - 1);
                    REG_TARGET_SPEED: mask = 16'((1 << SPEED_W) - 1);
                    REG_STEER_CENTER,
                    REG_STEER_MIN,
                    REG_STEER_MAX:    mask = 16'((1 << STEER_W) - 1);
                    default:          mask = 16'hFFFF;
                endcase
                raw = 16'($urandom);
                case ($urandom_range(0, 3))
                    0:       vals[i] = raw & ~mask;
                    1:       vals[i] = raw | mask;
                    default: vals[i] = raw;
                endcase
            end
        end
        for (int i = 0; i < 8; i++)
            write_reg(reg_index_t'(i), vals[i]);
    endtask

    always @(posedge clk)
    begin : result_sink
        cmd_pair_t want;
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (expected_cmds.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word %0d: steering_cmd %0d speed_cmd %0d",
                                 results_seen, steering_cmd, speed_cmd);
                end
                else
                begin
                    want = expected_cmds.pop_front();
                    if (steering_cmd !== want.steering || speed_cmd !== want.speed)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: steer exp %0d got %0d, speed exp %0d got %0d",
                                     results_seen, want.steering, steering_cmd,
                                     want.speed, speed_cmd);
                    end
                end
            end
            if (long_stall_req)
            begin
                stall_left = LONG_STALL;
                long_stall_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 13);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        bit quiet;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        lane_offset    = '0;
        out_ready      = 1'b0;
        mismatches     = 0;
        results_seen   = 0;
        stall_left     = 0;
        long_stall_req = 1'b0;
        idle_on        = 1'b1;
        cfg            = CFG_RESET;
        integral_acc   = 0;
        quiet          = 1'b1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_CFG)
            begin
                if (!quiet)
                begin
                    settle();
                    quiet = 1'b1;
                end
                write_reg(plan[i].idx, plan[i].value);
            end
            else
            begin
                quiet = 1'b0;
                push_offset(plan[i].value, plan[i].typed_ok, plan[i].typed);
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            set_phase_config(p % 2 == 1);
            idle_on = (p < PHASES - 2) && (p != 4);
            if (p == 2)
                long_stall_req = 1'b1;
            for (int k = 0; k < PHASE_WORDS; k++)
                push_offset(rand_offset(), 1'b0, NO_CMD);
        end

        settle();
        if (mismatches == 0 && expected_cmds.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
